// ----- design/exp_monomial_series_coefficient_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the series coefficient block
// Concurrent check wrappers; they compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef EXP_MONOMIAL_SERIES_COEFFICIENT_TOP_ASSERT_SVH
`define EXP_MONOMIAL_SERIES_COEFFICIENT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define EMSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("emsc assertion failed");
// expression must never be true out of reset
`define EMSC_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("emsc forbidden condition");
`else
`define EMSC_ASSERT(lbl, clk, rst_n, prop)
`define EMSC_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- design/emsc_pkg.sv -----
// ---------------------------------------------------------------------------
// emsc_pkg
// Shared widths, register indexes, status codes and unit handshake type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emsc_pkg;

    localparam int WORD_W     = 64;
    localparam int CNT_W      = $clog2(WORD_W + 1);
    localparam int STEP_W     = 20;
    localparam int LEN_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int STATUS_W   = 2;
    localparam int INDEX_BITS_DEF = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd3;

    // reset values
    localparam logic [WORD_W-1:0] RST_MODULUS = 64'd2;
    localparam logic [WORD_W-1:0] RST_COEF    = 64'd1;
    localparam logic [STEP_W-1:0] RST_STEP    = 20'd1;
    localparam logic [LEN_W-1:0]  RST_LENGTH  = 21'd0;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_POW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_INV   = 2'd3;

    // status from an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

// ----- design/emsc_div.sv -----
// ---------------------------------------------------------------------------
// emsc_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emsc_div import emsc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_num,
    input  wire logic [WORD_W-1:0] i_den,
    output logic      [WORD_W-1:0] o_quo,
    output logic      [WORD_W-1:0] o_rem,
    output t_unit_stat             o_stat
);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_quo, r_rem, r_den;
    logic [WORD_W:0]  w_trial, w_diff;
    logic             w_ge;

    // trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_quo[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WORD_W-1:0] : w_trial[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], w_ge};
        end
    end

    assign o_quo       = r_quo;
    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ----- design/emsc_mmul.sv -----
// ---------------------------------------------------------------------------
// emsc_mmul
// Modular multiplier, double-and-add from the top bit, one modular add per
// cycle. Operands must be below the modulus.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emsc_mmul import emsc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    input  wire logic [WORD_W-1:0] i_m,
    output logic      [WORD_W-1:0] o_prod,
    output t_unit_stat             o_stat
);

    logic              r_busy, r_done, r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_a, r_b, r_m, r_r, w_y;
    logic [WORD_W:0]   w_sum, w_red;

    // shared modular adder: doubling in phase 0, adding a in phase 1
    assign w_y   = r_phase ? r_a : r_r;
    assign w_sum = {1'b0, r_r} + {1'b0, w_y};
    assign w_red = (w_sum >= {1'b0, r_m}) ? w_sum - {1'b0, r_m} : w_sum;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= CNT_W'(WORD_W);
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
            r_r <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_r <= w_red[WORD_W-1:0];
            end else begin
                if (r_b[WORD_W-1]) begin
                    r_r <= w_red[WORD_W-1:0];
                end
                r_b <= {r_b[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_prod      = r_r;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ----- design/exp_monomial_series_coefficient_top.sv -----
// ---------------------------------------------------------------------------
// exp_monomial_series_coefficient_top
// One coefficient of exp(c*x^p) truncated to n terms, modulo m, per beat.
// ---------------------------------------------------------------------------
// One item is in flight at a time; the input stalls until it finishes, and
// its result then waits in an output register while the next item starts.
// Work runs on the shared modular multiplier and the shared divider, with
// k = i/p: range and step checks and the index divide, then k-1 products
// for k!, the Euclid steps of the inverse (a divide and a product each),
// c mod m, a squaring per bit of k plus a product per set bit of k, and
// the final product; the result then passes through the output
// register.
// Index past length, zero coefficient and zero power finish straight from
// the check state without a divide; an index off the step or with k at or
// past m finishes right after the index divide.
`timescale 1ns / 1ps
`default_nettype none
`include "exp_monomial_series_coefficient_top_assert.svh"

module exp_monomial_series_coefficient_top import emsc_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [WORD_W-1:0]     i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [INDEX_BITS-1:0] i_term_index,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [WORD_W-1:0]     o_term_value,
    output logic      [STATUS_W-1:0]   o_status
);

    localparam int CMP_W = ((INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W) + 1;
    localparam int J_W   = INDEX_BITS + 1;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_CHECK = 15'b000000000000010,
        S_DIVI  = 15'b000000000000100,
        S_FACT  = 15'b000000000001000,
        S_FACTW = 15'b000000000010000,
        S_EUC   = 15'b000000000100000,
        S_EUCD  = 15'b000000001000000,
        S_EUCM  = 15'b000000010000000,
        S_CRED  = 15'b000000100000000,
        S_POW   = 15'b000001000000000,
        S_POWA  = 15'b000010000000000,
        S_POWSQ = 15'b000100000000000,
        S_POWB  = 15'b001000000000000,
        S_FINM  = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } t_state;

    // configuration registers
    logic [WORD_W-1:0] r_modulus, r_coef;
    logic [STEP_W-1:0] r_step;
    logic [LEN_W-1:0]  r_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= RST_MODULUS;
            r_coef    <= RST_COEF;
            r_step    <= RST_STEP;
            r_length  <= RST_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODULUS: r_modulus <= i_cfg_data;
                CFG_COEF:    r_coef    <= i_cfg_data;
                CFG_STEP:    r_step    <= i_cfg_data[STEP_W-1:0];
                CFG_LENGTH:  r_length  <= i_cfg_data[LEN_W-1:0];
                default:     r_modulus <= r_modulus;
            endcase
        end
    end

    // sequencer and working registers
    t_state              r_state, n_state;
    logic [INDEX_BITS-1:0] r_i, n_i, r_k, n_k, r_e, n_e;
    logic [J_W-1:0]      r_j, n_j;
    logic [WORD_W-1:0]   r_m, n_m, r_f, n_f, r_r0, n_r0, r_r1, n_r1;
    logic [WORD_W-1:0]   r_t0, n_t0, r_t1, n_t1, r_acc, n_acc, r_base, n_base;
    logic [WORD_W-1:0]   r_res_val, n_res_val;
    logic [STATUS_W-1:0] r_res_st, n_res_st;
    logic                r_mul_go, n_mul_go, r_div_go, n_div_go;
    logic [WORD_W-1:0]   r_mul_a, n_mul_a, r_mul_b, n_mul_b;
    logic [WORD_W-1:0]   r_div_n, n_div_n, r_div_d, n_div_d;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_val;
    logic [STATUS_W-1:0] r_out_st;

    logic [WORD_W-1:0]   w_prod, w_quo, w_rem, w_qm, w_m_eff;
    t_unit_stat          w_mul_st, w_div_st;
    logic                w_in_acc, w_out_free;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_m_eff    = (r_modulus < 64'd2) ? 64'd2 : r_modulus;
    // Euclid quotient never exceeds m, so one subtract reduces it
    assign w_qm       = (w_quo >= r_m) ? w_quo - r_m : w_quo;

    emsc_mmul u_mmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .i_m     (r_m),
        .o_prod  (w_prod),
        .o_stat  (w_mul_st)
    );

    emsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_n),
        .i_den   (r_div_d),
        .o_quo   (w_quo),
        .o_rem   (w_rem),
        .o_stat  (w_div_st)
    );

    // next-state and datapath control
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_k       = r_k;
        n_e       = r_e;
        n_j       = r_j;
        n_m       = r_m;
        n_f       = r_f;
        n_r0      = r_r0;
        n_r1      = r_r1;
        n_t0      = r_t0;
        n_t1      = r_t1;
        n_acc     = r_acc;
        n_base    = r_base;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        n_mul_go  = 1'b0;
        n_mul_a   = r_mul_a;
        n_mul_b   = r_mul_b;
        n_div_go  = 1'b0;
        n_div_n   = r_div_n;
        n_div_d   = r_div_d;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_i     = i_term_index;
                    n_m     = w_m_eff;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res_val = '0;
                n_res_st  = ST_OK;
                if (CMP_W'(r_i) >= CMP_W'(r_length)) begin
                    n_res_st = ST_RANGE;
                    n_state  = S_DONE;
                end else if (r_coef == '0) begin
                    n_res_val = (r_i == '0) ? 64'd1 : 64'd0;
                    n_state   = S_DONE;
                end else if (r_step == '0) begin
                    n_res_st = ST_ZERO_POW;
                    n_state  = S_DONE;
                end else begin
                    n_div_go = 1'b1;
                    n_div_n  = WORD_W'(r_i);
                    n_div_d  = WORD_W'(r_step);
                    n_state  = S_DIVI;
                end
            end
            S_DIVI: begin
                if (w_div_st.done) begin
                    if (w_rem != '0) begin
                        n_state = S_DONE;
                    end else if (w_quo >= r_m) begin
                        n_res_st = ST_NO_INV;
                        n_state  = S_DONE;
                    end else begin
                        n_k     = w_quo[INDEX_BITS-1:0];
                        n_f     = 64'd1;
                        n_j     = J_W'(2);
                        n_state = S_FACT;
                    end
                end
            end
            // k! by repeated modular products
            S_FACT: begin
                if (r_j > {1'b0, r_k} || r_f == '0) begin
                    n_r0    = r_m;
                    n_r1    = r_f;
                    n_t0    = '0;
                    n_t1    = 64'd1;
                    n_state = S_EUC;
                end else begin
                    n_mul_go = 1'b1;
                    n_mul_a  = r_f;
                    n_mul_b  = WORD_W'(r_j);
                    n_state  = S_FACTW;
                end
            end
            S_FACTW: begin
                if (w_mul_st.done) begin
                    n_f     = w_prod;
                    n_j     = r_j + 1'b1;
                    n_state = S_FACT;
                end
            end
            // extended Euclid for the inverse of k!
            S_EUC: begin
                if (r_r1 == '0) begin
                    if (r_r0 != 64'd1) begin
                        n_res_st = ST_NO_INV;
                        n_state  = S_DONE;
                    end else begin
                        n_div_go = 1'b1;
                        n_div_n  = r_coef;
                        n_div_d  = r_m;
                        n_state  = S_CRED;
                    end
                end else begin
                    n_div_go = 1'b1;
                    n_div_n  = r_r0;
                    n_div_d  = r_r1;
                    n_state  = S_EUCD;
                end
            end
            S_EUCD: begin
                if (w_div_st.done) begin
                    n_r0     = r_r1;
                    n_r1     = w_rem;
                    n_mul_go = 1'b1;
                    n_mul_a  = w_qm;
                    n_mul_b  = r_t1;
                    n_state  = S_EUCM;
                end
            end
            S_EUCM: begin
                if (w_mul_st.done) begin
                    n_t0    = r_t1;
                    n_t1    = (r_t0 >= w_prod) ? r_t0 - w_prod : r_t0 - w_prod + r_m;
                    n_state = S_EUC;
                end
            end
            S_CRED: begin
                if (w_div_st.done) begin
                    n_base  = w_rem;
                    n_acc   = 64'd1;
                    n_e     = r_k;
                    n_state = S_POW;
                end
            end
            // c^k by square and multiply
            S_POW: begin
                if (r_e == '0) begin
                    n_mul_go = 1'b1;
                    n_mul_a  = r_acc;
                    n_mul_b  = r_t0;
                    n_state  = S_FINM;
                end else if (r_e[0]) begin
                    n_mul_go = 1'b1;
                    n_mul_a  = r_acc;
                    n_mul_b  = r_base;
                    n_state  = S_POWA;
                end else begin
                    n_state = S_POWSQ;
                end
            end
            S_POWA: begin
                if (w_mul_st.done) begin
                    n_acc   = w_prod;
                    n_state = S_POWSQ;
                end
            end
            S_POWSQ: begin
                n_mul_go = 1'b1;
                n_mul_a  = r_base;
                n_mul_b  = r_base;
                n_state  = S_POWB;
            end
            S_POWB: begin
                if (w_mul_st.done) begin
                    n_base  = w_prod;
                    n_e     = r_e >> 1;
                    n_state = S_POW;
                end
            end
            S_FINM: begin
                if (w_mul_st.done) begin
                    n_res_val = w_prod;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mul_go <= n_mul_go;
            r_div_go <= n_div_go;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_k       <= n_k;
        r_e       <= n_e;
        r_j       <= n_j;
        r_m       <= n_m;
        r_f       <= n_f;
        r_r0      <= n_r0;
        r_r1      <= n_r1;
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_acc     <= n_acc;
        r_base    <= n_base;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_mul_a   <= n_mul_a;
        r_mul_b   <= n_mul_b;
        r_div_n   <= n_div_n;
        r_div_d   <= n_div_d;
        if (r_state == S_DONE && w_out_free) begin
            r_out_val <= r_res_val;
            r_out_st  <= r_res_st;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_term_value = r_out_val;
    assign o_status     = r_out_st;

    // checks
    `EMSC_ASSERT(a_err_zero, i_clk, i_rst_n,
        (o_out_valid && o_status != ST_OK) |-> (o_term_value == '0))
    `EMSC_ASSERT(a_ok_below_m, i_clk, i_rst_n,
        (o_out_valid && o_status == ST_OK && r_state == S_IDLE) |-> (o_term_value < r_m))
    `EMSC_NEVER(a_mul_overlap, i_clk, i_rst_n, r_mul_go && w_mul_st.busy)
    `EMSC_NEVER(a_div_overlap, i_clk, i_rst_n, r_div_go && w_div_st.busy)

endmodule

`default_nettype wire
